// ===== rtl/pcrd_pkg.sv =====
// Shared widths, latencies, register codes and types for the pinhole camera ray generator.
// Used by every module under rtl; depends on nothing.
package pcrd_pkg;

    localparam int COORD_BITS    = 12;
    localparam int DIM_BITS      = COORD_BITS + 1;
    localparam int VEC_FRAC_BITS = 14;
    localparam int VEC_BITS      = VEC_FRAC_BITS + 2;
    localparam int VEC_REG_BITS  = 3 * VEC_BITS;
    localparam int SCALE_BITS    = 16;
    localparam int SCALE_FRAC    = 12;
    localparam int SCR_FRAC      = 16;

    // Screen coordinate divider and view scaling.
    localparam int SNUM_BITS = DIM_BITS + SCR_FRAC;
    localparam int PROD_BITS = SNUM_BITS + SCALE_BITS;
    localparam int TM_BITS   = PROD_BITS - SCALE_FRAC;
    localparam int T_BITS    = TM_BITS + 1;

    // Basis combination and normalization window.
    localparam int PR_BITS  = VEC_BITS + T_BITS;
    localparam int C_BITS   = PR_BITS + 2;
    localparam int NSH      = $clog2(C_BITS);
    localparam int NW_BITS  = 2 ** NSH;
    localparam int NORM_TOP = 30;

    // Length and final division.
    localparam int SQ_BITS   = 2 * NORM_TOP;
    localparam int SUM_BITS  = SQ_BITS + 2;
    localparam int SQ_STEPS  = SUM_BITS / 2;
    localparam int LEN_BITS  = NORM_TOP + 1;
    localparam int OUT_FRAC  = 15;
    localparam int OUT_BITS  = 16;
    localparam int QN_BITS   = NORM_TOP + OUT_FRAC + 1;
    localparam int Q_STEPS   = OUT_FRAC + 1;

    // Register stages of each unit.
    localparam int LAT_SCR = SNUM_BITS + 3;
    localparam int LAT_NRM = NSH + 2;
    localparam int LAT_SQ  = SQ_STEPS + 2;
    localparam int LAT_QUO = Q_STEPS + 2;
    localparam int LAT_TOT = LAT_SCR + LAT_NRM + LAT_SQ + LAT_QUO;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = VEC_REG_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FORWARD,
        CFG_RIGHT,
        CFG_UP,
        CFG_SCALE,
        CFG_WIDTH,
        CFG_HEIGHT
    } t_cfg_idx;

    localparam logic [VEC_REG_BITS-1:0] RST_FORWARD = VEC_REG_BITS'(1 << VEC_FRAC_BITS);
    localparam logic [VEC_REG_BITS-1:0] RST_RIGHT   = '0;
    localparam logic [VEC_REG_BITS-1:0] RST_UP      = '0;
    localparam logic [SCALE_BITS-1:0]   RST_SCALE   = SCALE_BITS'(1 << SCALE_FRAC);
    localparam logic [DIM_BITS-1:0]     RST_WIDTH   = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0]     RST_HEIGHT  = DIM_BITS'(480);

    // Normalized direction handed from the normalizer to the length and divide stages.
    typedef struct packed {
        logic [2:0][NORM_TOP-1:0] mag;
        logic [2:0]               neg;
        logic                     zero;
    } t_nrm;

endpackage

// ===== rtl/pinhole_camera_ray_direction.sv =====
// Pinhole camera primary ray direction generator, top level.
// Depends on pcrd_pkg, pcrd_screen, pcrd_norm, pcrd_isqrt and pcrd_quot.
//
// Usage: each input beat carries one pixel coordinate (i_pixel_x, i_pixel_y) and yields
// exactly one output beat holding the unit direction (o_dir_x, o_dir_y, o_dir_z) in signed
// Q1.15 of the ray through the center of that pixel. Results leave in input order.
// The camera basis, view scale and image size are written through the configuration
// channel (i_cfg_valid, i_cfg_index, i_cfg_data); o_cfg_ready is always high. Registers must
// only be changed while no pixel is in flight, since every stage reads them directly.
// The pipeline takes one beat per cycle while o_stall is low: the screen dividers give one
// quotient bit per stage, the square root one root bit per stage and the final dividers one
// output bit per stage, so no unit loops.
// Reset (synchronous, active low) empties the pipeline and output buffer and restores the
// default camera: forward (1,0,0), no right or up axis, scale 1.0, 640 by 480 pixels.
// When the receiver stalls, the finished result holds on the outputs and the pipeline keeps
// moving until one more result has landed in a skid register; only then is o_stall raised
// and the whole pipeline frozen. o_stall is a register output.
module pinhole_camera_ray_direction (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic [pcrd_pkg::COORD_BITS-1:0]          i_pixel_x,
    input  logic [pcrd_pkg::COORD_BITS-1:0]          i_pixel_y,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic signed [pcrd_pkg::OUT_BITS-1:0]     o_dir_x,
    output logic signed [pcrd_pkg::OUT_BITS-1:0]     o_dir_y,
    output logic signed [pcrd_pkg::OUT_BITS-1:0]     o_dir_z,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [pcrd_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [pcrd_pkg::CFG_DATA_BITS-1:0]       i_cfg_data
);
    localparam int LAT = pcrd_pkg::LAT_TOT;
    localparam int LSQ = pcrd_pkg::LAT_SQ;
    localparam int OB  = pcrd_pkg::OUT_BITS;

    // Configuration registers.
    logic [pcrd_pkg::VEC_REG_BITS-1:0] r_fwd;
    logic [pcrd_pkg::VEC_REG_BITS-1:0] r_right;
    logic [pcrd_pkg::VEC_REG_BITS-1:0] r_up;
    logic [pcrd_pkg::SCALE_BITS-1:0]   r_scale;
    logic [pcrd_pkg::DIM_BITS-1:0]     r_width;
    logic [pcrd_pkg::DIM_BITS-1:0]     r_height;

    logic                                 en;
    logic                                 accept;
    logic [LAT-1:0]                       r_vld;
    logic signed [pcrd_pkg::T_BITS-1:0]   tx;
    logic signed [pcrd_pkg::T_BITS-1:0]   ty;
    pcrd_pkg::t_nrm                       nrm;
    pcrd_pkg::t_nrm                       r_dly [LSQ];
    logic [pcrd_pkg::LEN_BITS-1:0]        len;
    logic signed [OB-1:0]                 dir [3];

    // Output register plus one skid entry.
    logic                     r_out_v;
    logic                     r_skid_v;
    logic [2:0][OB-1:0]       r_out;
    logic [2:0][OB-1:0]       r_skid;
    logic [2:0][OB-1:0]       pipe_dir;
    logic                     take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd    <= pcrd_pkg::RST_FORWARD;
            r_right  <= pcrd_pkg::RST_RIGHT;
            r_up     <= pcrd_pkg::RST_UP;
            r_scale  <= pcrd_pkg::RST_SCALE;
            r_width  <= pcrd_pkg::RST_WIDTH;
            r_height <= pcrd_pkg::RST_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (pcrd_pkg::t_cfg_idx'(i_cfg_index))
                pcrd_pkg::CFG_FORWARD: r_fwd    <= i_cfg_data;
                pcrd_pkg::CFG_RIGHT:   r_right  <= i_cfg_data;
                pcrd_pkg::CFG_UP:      r_up     <= i_cfg_data;
                pcrd_pkg::CFG_SCALE:   r_scale  <= i_cfg_data[pcrd_pkg::SCALE_BITS-1:0];
                pcrd_pkg::CFG_WIDTH:   r_width  <= i_cfg_data[pcrd_pkg::DIM_BITS-1:0];
                pcrd_pkg::CFG_HEIGHT:  r_height <= i_cfg_data[pcrd_pkg::DIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together unless the skid entry is occupied.
    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;
    assign accept  = i_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    pcrd_screen u_scr_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_flip  (1'b0),
        .i_p     (i_pixel_x),
        .i_n     (r_width),
        .i_scale (r_scale),
        .o_t     (tx)
    );

    // Rows grow downward while screen Y grows upward.
    pcrd_screen u_scr_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_flip  (1'b1),
        .i_p     (i_pixel_y),
        .i_n     (r_height),
        .i_scale (r_scale),
        .o_t     (ty)
    );

    pcrd_norm u_norm (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_tx    (tx),
        .i_ty    (ty),
        .i_fwd   (r_fwd),
        .i_right (r_right),
        .i_up    (r_up),
        .o_nrm   (nrm)
    );

    pcrd_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (nrm.mag),
        .o_len (len)
    );

    // Magnitudes and signs wait alongside the square root.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= nrm;
            for (int k = 1; k < LSQ; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_quot
        pcrd_quot u_quot (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_mag  (r_dly[LSQ-1].mag[c]),
            .i_neg  (r_dly[LSQ-1].neg[c]),
            .i_zero (r_dly[LSQ-1].zero),
            .i_len  (len),
            .o_dir  (dir[c])
        );
        assign pipe_dir[c] = dir[c];
    end

    assign take = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            priority if (r_skid_v) begin
                if (take) begin
                    r_skid_v <= 1'b0;
                end
            end else if (r_vld[LAT-1]) begin
                if (r_out_v && !take) begin
                    r_skid_v <= 1'b1;
                end
                r_out_v <= 1'b1;
            end else if (take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (r_vld[LAT-1]) begin
            if (r_out_v && !take) begin
                r_skid <= pipe_dir;
            end else begin
                r_out <= pipe_dir;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_dir_x = $signed(r_out[0]);
    assign o_dir_y = $signed(r_out[1]);
    assign o_dir_z = $signed(r_out[2]);

    // The skid entry is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry valid while output register empty");

    // The skid entry fills only when the output was full and held by the receiver.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid entry filled without a stalled output");

    // A result leaving the pipeline always lands in the output buffer.
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_v && r_vld[LAT-1]) |=> r_out_v)
        else $error("pipeline result lost at the output buffer");

endmodule

// ===== rtl/pcrd_screen.sv =====
// Screen coordinate of one axis: restoring divider by the image size, then view scaling.
// Depends on pcrd_pkg.
module pcrd_screen (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic                                 i_flip,
    input  logic [pcrd_pkg::COORD_BITS-1:0]      i_p,
    input  logic [pcrd_pkg::DIM_BITS-1:0]        i_n,
    input  logic [pcrd_pkg::SCALE_BITS-1:0]      i_scale,
    output logic signed [pcrd_pkg::T_BITS-1:0]   o_t
);
    localparam int DB = pcrd_pkg::DIM_BITS;
    localparam int NB = pcrd_pkg::SNUM_BITS;
    localparam int PB = pcrd_pkg::PROD_BITS;
    localparam int TB = pcrd_pkg::T_BITS;
    localparam int WB = NB + DB;

    logic [DB-1:0]   d;
    logic [DB+1:0]   num;
    logic [DB+1:0]   num_abs;
    logic            num_neg;
    logic [NB-1:0]   n0;
    logic [PB-1:0]   tm_full;

    logic [NB-1:0]   r_rem [0:NB];
    logic [NB-1:0]   r_q   [0:NB];
    logic            r_sgn [0:NB];
    logic [PB-1:0]   r_prod;
    logic            r_sgnp;
    logic [TB-1:0]   r_t;

    // A zero size register behaves as one.
    assign d       = (i_n == '0) ? DB'(1) : i_n;
    assign num     = (DB+2)'({i_p, 1'b1}) - (DB+2)'(d);
    assign num_neg = num[DB+1];
    assign num_abs = num_neg ? -num : num;
    assign n0      = {num_abs[DB-1:0], pcrd_pkg::SCR_FRAC'(0)} + NB'(d >> 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n0;
            r_q[0]   <= '0;
            r_sgn[0] <= num_neg ^ i_flip;
        end
    end

    for (genvar k = 1; k <= NB; k++) begin : g_div
        localparam int B = NB - k;
        logic [WB-1:0] dsh;
        assign dsh = WB'(d) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sgn[k] <= r_sgn[k-1];
                if (WB'(r_rem[k-1]) >= dsh) begin
                    r_rem[k] <= r_rem[k-1] - NB'(dsh);
                    r_q[k]   <= r_q[k-1] | (NB'(1) << B);
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_q[k]   <= r_q[k-1];
                end
            end
        end
    end

    assign tm_full = (r_prod + PB'(1 << (pcrd_pkg::SCALE_FRAC - 1))) >> pcrd_pkg::SCALE_FRAC;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PB'(r_q[NB]) * PB'(i_scale);
            r_sgnp <= r_sgn[NB];
            r_t    <= r_sgnp ? -TB'(tm_full) : TB'(tm_full);
        end
    end

    assign o_t = $signed(r_t);

endmodule

// ===== rtl/pcrd_norm.sv =====
// Combines the camera basis with the scaled screen offsets and normalizes the magnitudes.
// Depends on pcrd_pkg.
module pcrd_norm (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [pcrd_pkg::T_BITS-1:0]     i_tx,
    input  logic signed [pcrd_pkg::T_BITS-1:0]     i_ty,
    input  logic [pcrd_pkg::VEC_REG_BITS-1:0]      i_fwd,
    input  logic [pcrd_pkg::VEC_REG_BITS-1:0]      i_right,
    input  logic [pcrd_pkg::VEC_REG_BITS-1:0]      i_up,
    output pcrd_pkg::t_nrm                         o_nrm
);
    localparam int VB  = pcrd_pkg::VEC_BITS;
    localparam int CB  = pcrd_pkg::C_BITS;
    localparam int NW  = pcrd_pkg::NW_BITS;
    localparam int NS  = pcrd_pkg::NSH;
    localparam int TOP = pcrd_pkg::NORM_TOP;

    logic signed [VB-1:0]                 cf [3];
    logic signed [VB-1:0]                 cr [3];
    logic signed [VB-1:0]                 cu [3];
    logic signed [pcrd_pkg::PR_BITS-1:0]  r_pr [3];
    logic signed [pcrd_pkg::PR_BITS-1:0]  r_pu [3];
    logic signed [VB-1:0]                 r_f  [3];
    logic signed [CB-1:0]                 csum [3];
    logic [2:0][NW-1:0]                   r_m   [0:NS];
    logic [2:0]                           r_neg [0:NS];
    logic                                 r_zero[0:NS];

    for (genvar c = 0; c < 3; c++) begin : g_comb
        assign cf[c]   = $signed(i_fwd[c*VB +: VB]);
        assign cr[c]   = $signed(i_right[c*VB +: VB]);
        assign cu[c]   = $signed(i_up[c*VB +: VB]);
        assign csum[c] = (CB'(r_f[c]) <<< pcrd_pkg::SCR_FRAC) + CB'(r_pr[c]) + CB'(r_pu[c]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pr[c]     <= cr[c] * i_tx;
                r_pu[c]     <= cu[c] * i_ty;
                r_f[c]      <= cf[c];
                r_neg[0][c] <= csum[c][CB-1];
                r_m[0][c]   <= NW'(csum[c][CB-1] ? -csum[c] : csum[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (csum[0] == '0) && (csum[1] == '0) && (csum[2] == '0);
        end
    end

    // Each stage shifts all three left when the largest still has that many leading zeros.
    for (genvar k = 1; k <= NS; k++) begin : g_sh
        localparam int S = 2 ** (NS - k);
        logic hole;
        assign hole = ((r_m[k-1][0] | r_m[k-1][1] | r_m[k-1][2]) >> (NW - S)) == '0;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
                for (int c = 0; c < 3; c++) begin
                    r_m[k][c] <= hole ? (r_m[k-1][c] << S) : r_m[k-1][c];
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            o_nrm.mag[c] = r_m[NS][c][NW-1 -: TOP];
        end
        o_nrm.neg  = r_neg[NS];
        o_nrm.zero = r_zero[NS];
    end

endmodule

// ===== rtl/pcrd_isqrt.sv =====
// Sum of squares of the normalized magnitudes and a pipelined integer square root.
// Depends on pcrd_pkg.
module pcrd_isqrt (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  logic [2:0][pcrd_pkg::NORM_TOP-1:0]         i_mag,
    output logic [pcrd_pkg::LEN_BITS-1:0]              o_len
);
    localparam int SB = pcrd_pkg::SUM_BITS;
    localparam int QB = pcrd_pkg::SQ_BITS;
    localparam int NS = pcrd_pkg::SQ_STEPS;

    logic [QB-1:0] r_sq [3];
    logic [SB-1:0] r_v  [0:NS];
    logic [SB-1:0] r_r  [0:NS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= QB'(i_mag[c]) * QB'(i_mag[c]);
            end
            r_v[0] <= SB'(r_sq[0]) + SB'(r_sq[1]) + SB'(r_sq[2]);
            r_r[0] <= '0;
        end
    end

    // One result bit per stage, highest first.
    for (genvar k = 1; k <= NS; k++) begin : g_root
        localparam logic [SB:0] BIT = (SB+1)'(1) << (2 * (NS - k));
        logic [SB:0] rb;
        assign rb = (SB+1)'(r_r[k-1]) + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ((SB+1)'(r_v[k-1]) >= rb) begin
                    r_v[k] <= r_v[k-1] - SB'(rb);
                    r_r[k] <= SB'((SB+1)'(r_r[k-1] >> 1) + BIT);
                end else begin
                    r_v[k] <= r_v[k-1];
                    r_r[k] <= r_r[k-1] >> 1;
                end
            end
        end
    end

    assign o_len = r_r[NS][pcrd_pkg::LEN_BITS-1:0];

endmodule

// ===== rtl/pcrd_quot.sv =====
// One output component: rounded magnitude/length divide, sign restore and saturation, or zero for a zero sum.
// Depends on pcrd_pkg.
module pcrd_quot (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [pcrd_pkg::NORM_TOP-1:0]          i_mag,
    input  logic                                   i_neg,
    input  logic                                   i_zero,
    input  logic [pcrd_pkg::LEN_BITS-1:0]          i_len,
    output logic signed [pcrd_pkg::OUT_BITS-1:0]   o_dir
);
    localparam int QN = pcrd_pkg::QN_BITS;
    localparam int QS = pcrd_pkg::Q_STEPS;
    localparam int LB = pcrd_pkg::LEN_BITS;
    localparam int OB = pcrd_pkg::OUT_BITS;
    localparam logic [QS-1:0] POS_MAX = QS'((1 << (OB - 1)) - 1);
    localparam logic [QS-1:0] NEG_MAX = QS'(1 << (OB - 1));

    logic [QN-1:0] r_rem  [0:QS];
    logic [QS-1:0] r_q    [0:QS];
    logic [LB-1:0] r_len  [0:QS];
    logic          r_neg  [0:QS];
    logic          r_zero [0:QS];
    logic [OB-1:0] r_dir;
    logic [QS-1:0] q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= QN'({i_mag, pcrd_pkg::OUT_FRAC'(0)}) + QN'(i_len >> 1);
            r_q[0]    <= '0;
            r_len[0]  <= i_len;
            r_neg[0]  <= i_neg;
            r_zero[0] <= i_zero;
        end
    end

    for (genvar k = 1; k <= QS; k++) begin : g_div
        localparam int B = QS - k;
        logic [QN:0] dsh;
        assign dsh = (QN+1)'(r_len[k-1]) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[k]  <= r_len[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
                if ((QN+1)'(r_rem[k-1]) >= dsh) begin
                    r_rem[k] <= r_rem[k-1] - QN'(dsh);
                    r_q[k]   <= r_q[k-1] | (QS'(1) << B);
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_q[k]   <= r_q[k-1];
                end
            end
        end
    end

    assign q = r_q[QS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zero[QS]) begin
                r_dir <= '0;
            end else if (r_neg[QS]) begin
                r_dir <= (q > NEG_MAX) ? OB'(NEG_MAX) : -OB'(q);
            end else begin
                r_dir <= (q > POS_MAX) ? OB'(POS_MAX) : OB'(q);
            end
        end
    end

    assign o_dir = $signed(r_dir);

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for pinhole_camera_ray_direction: directed table, then random pixels.
// Depends on pcrd_pkg and the RTL top level; computes expected ray directions itself.
`timescale 1ns / 100ps

module testbench;

    // Each expected beat holds one ray direction in signed Q1.15.
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_dir;

    // One row of the directed table. When has_dir is set, dir is the value the
    // row must produce, and the predictor is also checked against it.
    typedef struct {
        logic [11:0] px;
        logic [11:0] py;
        bit          has_dir;
        t_dir        dir;
    } t_row;

    logic                                     i_clk;
    logic                                     i_rst_n;
    logic                                     i_valid;
    logic                                     o_stall;
    logic [pcrd_pkg::COORD_BITS-1:0]          i_pixel_x;
    logic [pcrd_pkg::COORD_BITS-1:0]          i_pixel_y;
    logic                                     o_valid;
    logic                                     i_stall;
    logic signed [pcrd_pkg::OUT_BITS-1:0]     o_dir_x;
    logic signed [pcrd_pkg::OUT_BITS-1:0]     o_dir_y;
    logic signed [pcrd_pkg::OUT_BITS-1:0]     o_dir_z;
    logic                                     i_cfg_valid;
    logic                                     o_cfg_ready;
    logic [pcrd_pkg::CFG_IDX_BITS-1:0]        i_cfg_index;
    logic [pcrd_pkg::CFG_DATA_BITS-1:0]       i_cfg_data;

    pinhole_camera_ray_direction uut (.*);

    // The bench keeps its own copy of the camera registers.
    logic [47:0] cam_fwd, cam_right, cam_up;
    logic [15:0] cam_scale;
    logic [12:0] cam_w, cam_h;

    t_dir pending_dirs[$];
    int   mismatches;
    bit   hold_off;       // long receiver stall requested by the stimulus process
    bit   stall_pattern;  // random receiver stalls enabled

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("** pinhole_camera_ray_direction: FAILED **");
        $finish;
    end

    // Rounded division, ties away from zero, as used for screen coordinates.
    function automatic longint round_div(longint a, longint b);
        if (a >= 0) return (a + b / 2) / b;
        return -((-a + b / 2) / b);
    endfunction

    // Screen offset of one pixel coordinate, scaled by tan(fov/2), 16 fraction bits.
    function automatic longint screen_offset(logic [11:0] p, logic [12:0] n, bit flip);
        longint d, s;
        d = (n == 0) ? 1 : longint'(n);
        s = round_div((2 * longint'(p) + 1 - d) * 65536, d);
        if (flip) s = -s;
        return round_div(s * longint'(cam_scale), 4096);
    endfunction

    function automatic longint basis_comp(logic [47:0] v, int k);
        return longint'($signed(v[16*k +: 16]));
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit same_dir(t_dir a, t_dir b);
        return (a.x === b.x) && (a.y === b.y) && (a.z === b.z);
    endfunction

    // Expected unit direction of the ray through pixel (px, py).
    function automatic t_dir ray_direction(logic [11:0] px, logic [11:0] py);
        longint      tx, ty, c;
        logic [63:0] mag[3];
        bit          neg[3];
        logic [63:0] top, sum, len, q;
        logic signed [15:0] o[3];
        t_dir        d;
        tx  = screen_offset(px, cam_w, 1'b0);
        ty  = screen_offset(py, cam_h, 1'b1);
        top = 0;
        for (int k = 0; k < 3; k++) begin
            c = basis_comp(cam_fwd, k) * 65536 + basis_comp(cam_right, k) * tx
              + basis_comp(cam_up, k) * ty;
            neg[k] = c < 0;
            mag[k] = neg[k] ? -c : c;
            if (mag[k] > top) top = mag[k];
        end
        if (top == 0) begin
            d.x = 0; d.y = 0; d.z = 0;
            return d;
        end
        while (top >= (64'd1 << 30)) begin
            top = top >> 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
        end
        while (top < (64'd1 << 29)) begin
            top = top << 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
        end
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = int_sqrt(sum);
        if (len == 0) len = 1;
        for (int k = 0; k < 3; k++) begin
            q = ((mag[k] << 15) + len / 2) / len;
            if (neg[k]) o[k] = (q > 32768) ? -16'sd32768 : -$signed(q[15:0]);
            else        o[k] = (q > 32767) ? 16'sd32767 : $signed(q[15:0]);
        end
        d.x = o[0]; d.y = o[1]; d.z = o[2];
        return d;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Output checker: every accepted beat is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_dirs.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                t_dir e;
                e = pending_dirs.pop_front();
                if (o_dir_x !== e.x)
                    report_mismatch($sformatf("dir_x got %0d, expected %0d", o_dir_x, e.x));
                if (o_dir_y !== e.y)
                    report_mismatch($sformatf("dir_y got %0d, expected %0d", o_dir_y, e.y));
                if (o_dir_z !== e.z)
                    report_mismatch($sformatf("dir_z got %0d, expected %0d", o_dir_z, e.z));
            end
        end
    end

    // Receiver stall: a random pattern of stall runs and free runs, plus the long
    // hold-off that the stimulus asks for to back up the pipeline.
    initial begin
        int run;
        bit level;
        i_stall = 1'b0;
        level   = 1'b0;
        run     = 0;
        forever begin
            @(posedge i_clk);
            if (run == 0) begin
                level = ($urandom_range(0, 2) == 0);
                run   = level ? $urandom_range(1, 6) : $urandom_range(1, 25);
            end
            run--;
            i_stall <= hold_off || (stall_pattern && level);
        end
    end

    // Sends one pixel beat and records its expected direction once accepted.
    task automatic send_pixel(logic [11:0] px, logic [11:0] py);
        i_valid   <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        do @(posedge i_clk); while (o_stall);
        pending_dirs.push_back(ray_direction(px, py));
    endtask

    // Lowers valid for a random gap, ending a burst.
    task automatic idle_gap(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Waits until all expected beats have arrived, then lets the pipeline drain.
    task automatic drain_pipeline();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (pending_dirs.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_dirs.size() != 0) begin
            $display("** pinhole_camera_ray_direction: FAILED **");
            $finish;
        end
        repeat (pcrd_pkg::LAT_TOT + 10) @(posedge i_clk);
    endtask

    task automatic write_register(pcrd_pkg::t_cfg_idx idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            pcrd_pkg::CFG_FORWARD: cam_fwd   = data;
            pcrd_pkg::CFG_RIGHT:   cam_right = data;
            pcrd_pkg::CFG_UP:      cam_up    = data;
            pcrd_pkg::CFG_SCALE:   cam_scale = data[15:0];
            pcrd_pkg::CFG_WIDTH:   cam_w     = data[12:0];
            pcrd_pkg::CFG_HEIGHT:  cam_h     = data[12:0];
            default: ;
        endcase
    endtask

    function automatic logic [47:0] pack_vec(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    // A random basis vector: mostly moderate components, sometimes full range.
    function automatic logic [47:0] random_vec();
        if ($urandom_range(0, 3) == 0) return 48'({$urandom, $urandom});
        return pack_vec($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                        $urandom_range(0, 32768) - 16384);
    endfunction

    task automatic write_camera(logic [47:0] f, logic [47:0] r, logic [47:0] u,
                                logic [15:0] s, logic [12:0] w, logic [12:0] h);
        write_register(pcrd_pkg::CFG_FORWARD, f);
        write_register(pcrd_pkg::CFG_RIGHT, r);
        write_register(pcrd_pkg::CFG_UP, u);
        write_register(pcrd_pkg::CFG_SCALE, {32'd0, s});
        write_register(pcrd_pkg::CFG_WIDTH, {35'd0, w});
        write_register(pcrd_pkg::CFG_HEIGHT, {35'd0, h});
    endtask

    task automatic random_burst(int count);
        int left;
        logic [11:0] px, py;
        left = count;
        while (left > 0) begin
            for (int k = $urandom_range(1, 30); k > 0 && left > 0; k--) begin
                // Mostly pixels inside the image, sometimes anywhere in the field.
                if ($urandom_range(0, 4) == 0) begin
                    px = $urandom;
                    py = $urandom;
                end else begin
                    px = (cam_w == 0) ? 12'd0 : 12'($urandom_range(0, cam_w - 1));
                    py = (cam_h == 0) ? 12'd0 : 12'($urandom_range(0, cam_h - 1));
                end
                send_pixel(px, py);
                left--;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
        end
    endtask

    t_row rows[$];

    initial begin
        t_dir d;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_pixel_x     = '0;
        i_pixel_y     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = pcrd_pkg::CFG_FORWARD;
        i_cfg_data    = '0;
        hold_off      = 1'b0;
        stall_pattern = 1'b0;
        mismatches    = 0;
        cam_fwd   = pcrd_pkg::RST_FORWARD;
        cam_right = pcrd_pkg::RST_RIGHT;
        cam_up    = pcrd_pkg::RST_UP;
        cam_scale = pcrd_pkg::RST_SCALE;
        cam_w     = pcrd_pkg::RST_WIDTH;
        cam_h     = pcrd_pkg::RST_HEIGHT;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset only the forward axis is set, so every ray points along +x
        // and the unit component saturates to the largest positive value.
        d.x = 16'sd32767; d.y = 0; d.z = 0;
        rows.push_back('{12'd0, 12'd0, 1'b1, d});
        rows.push_back('{12'd4095, 12'd4095, 1'b1, d});
        rows.push_back('{12'd320, 12'd240, 1'b1, d});
        foreach (rows[i]) begin
            if (!same_dir(ray_direction(rows[i].px, rows[i].py), rows[i].dir))
                report_mismatch($sformatf("predictor disagrees with table row %0d", i));
            send_pixel(rows[i].px, rows[i].py);
        end
        drain_pipeline();

        // A full camera: forward +x, right +y, up +z, 90 degree field of view.
        write_camera(pack_vec(16384, 0, 0), pack_vec(0, 16384, 0), pack_vec(0, 0, 16384),
                     16'd4096, 13'd640, 13'd480);
        rows.delete();
        rows.push_back('{12'd0, 12'd0, 1'b0, d});
        rows.push_back('{12'd639, 12'd479, 1'b0, d});
        rows.push_back('{12'd319, 12'd239, 1'b0, d});
        rows.push_back('{12'd4095, 12'd0, 1'b0, d});
        rows.push_back('{12'd0, 12'd4095, 1'b0, d});
        rows.push_back('{12'hAAA, 12'h555, 1'b0, d});
        rows.push_back('{12'h555, 12'hAAA, 1'b0, d});
        foreach (rows[i]) send_pixel(rows[i].px, rows[i].py);
        drain_pipeline();

        // Zero direction sum: no axes at all gives an all-zero result.
        write_camera(48'd0, 48'd0, 48'd0, 16'hFFFF, 13'd0, 13'd0);
        d.x = 0; d.y = 0; d.z = 0;
        if (!same_dir(ray_direction(12'd7, 12'd9), d))
            report_mismatch("predictor gives a nonzero ray for a zero basis");
        send_pixel(12'd7, 12'd9);
        send_pixel(12'd4095, 12'd0);
        drain_pipeline();
        // Zero image size acts as one pixel; negative extremes on every axis.
        write_camera(pack_vec(-32768, -32768, -32768), pack_vec(32767, -32768, 32767),
                     pack_vec(-32768, 32767, 32767), 16'hFFFF, 13'd0, 13'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        drain_pipeline();
        write_camera(pack_vec(0, 0, -16384), pack_vec(16384, 0, 0), pack_vec(0, 16384, 0),
                     16'd0, 13'd4096, 13'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        drain_pipeline();

        // Random phases, each with its own camera, under random receiver stalls.
        stall_pattern = 1'b1;
        for (int phase = 0; phase < 10; phase++) begin
            logic [12:0] w, h;
            w = (phase == 3) ? 13'd4096 : (phase == 4) ? 13'd1 : 13'($urandom_range(1, 800));
            h = (phase == 3) ? 13'd1 : (phase == 4) ? 13'd4096 : 13'($urandom_range(1, 800));
            write_camera(random_vec(), random_vec(), random_vec(),
                         (phase == 5) ? 16'hFFFF : 16'($urandom_range(0, 12000)), w, h);
            if (phase == 6) begin
                // Long hold-off: the sender keeps offering until the pipeline backs up.
                hold_off = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                    random_burst(200);
                join
            end else begin
                random_burst(90);
            end
            drain_pipeline();
        end

        if (mismatches == 0) $display("** pinhole_camera_ray_direction: PASSED **");
        else $display("** pinhole_camera_ray_direction: FAILED **");
        $finish;
    end

endmodule

// ===== pinhole_camera_ray_direction.f =====
rtl/pcrd_pkg.sv
rtl/pcrd_screen.sv
rtl/pcrd_norm.sv
rtl/pcrd_isqrt.sv
rtl/pcrd_quot.sv
rtl/pinhole_camera_ray_direction.sv
bench/testbench.sv
